// ----- rtl/moving_sphere_collision_test_defines.svh -----
// Assertion macros shared by the moving sphere collision test RTL.
`ifndef MOVING_SPHERE_COLLISION_TEST_DEFINES_SVH
`define MOVING_SPHERE_COLLISION_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define MSCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define MSCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/msct_pkg.sv -----
// Package with widths, constants and shared types of the collision test.
`timescale 1ns / 1ps
package msct_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int ID_BITS_DEFAULT       = 16;

    localparam int COORD_W = 32;   // signed Q16.16 inputs
    localparam int R_W     = 31;   // radius sum
    localparam int H_W     = 31;   // half step register
    localparam int TAG_W   = 4;
    localparam int PROD_W  = 64;   // exact sums of squares
    localparam int NW      = 61;   // normalized coefficient magnitudes
    localparam int SPLIT   = 31;   // low part of a split coefficient
    localparam int HI_W    = NW - SPLIT;
    localparam int PW      = 2 * NW;        // product of two coefficients
    localparam int DW      = PW + 1;        // discriminant
    localparam int RW      = 62;            // square root bits
    localparam int SW      = 2 * RW;        // square root remainder
    localparam int QW      = RW + 1;        // |q| = |b/2| + root
    localparam int QB      = 33;            // quotient bits kept
    localparam int CW      = QW + QB;       // divider remainder
    localparam int TIME_W  = 32;
    localparam int TM_W    = TIME_W + 1;    // clipped time magnitude
    localparam int TS_W    = TM_W + 1;      // signed clipped time
    localparam int FRONT_STAGES = 8;

    localparam logic [H_W-1:0]  HALF_STEP_RESET = H_W'(32768);
    localparam logic [TM_W-1:0] TIME_CAP        = TM_W'(1) << TIME_W;

    typedef struct packed {
        logic [TAG_W-1:0] ghost_tag;
        logic             crossing;
    } tag_t;

    typedef struct packed {
        logic [NW-1:0] a;
        logic [NW-1:0] bm;
        logic [NW-1:0] cm;
        logic          b_neg;
        logic          c_neg;
    } norm_t;

endpackage

// ----- rtl/moving_sphere_collision_test.sv -----
// Top level of the moving sphere collision test pipeline.
`timescale 1ns / 1ps
`include "moving_sphere_collision_test_defines.svh"
// Usage:
// Each input word is one candidate sphere pair: relative offset and velocity,
// radius sum, two particle ids, a ghost tag and a crossing flag. A word is
// taken at a rising edge with item_valid high and item_stall low. Every word
// yields exactly one result word on the result channel, taken at an edge
// with result_valid high and result_stall low; hit tells whether the pair
// meets inside the window set by half_step_length, and contact_time gives
// the time of first contact (zero for a miss or when the roots straddle).
// The pipeline is made of 8 front end stages, 62 square root stages (one
// root bit each), one stage that forms |q|, 34 divider stages (a scaling
// stage, then one quotient bit each) and the output register. Throughput is
// one word per cycle while item_stall is low.
// A stalled result is held in the output register; one more word lands in a
// skid register, after which item_stall rises and the whole pipeline holds.
// Reset clears all valid bits and loads half_step_length with 0.5 (32768);
// the register should only be written while no words are in flight.
module moving_sphere_collision_test #(
    parameter int FRACTION_BITS = msct_pkg::FRACTION_BITS_DEFAULT,
    parameter int ID_BITS       = msct_pkg::ID_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          half_step_length_we,
    input  logic [msct_pkg::H_W-1:0]      half_step_length,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [ID_BITS-1:0]            first_id,
    input  logic [ID_BITS-1:0]            second_id,
    input  logic signed [msct_pkg::COORD_W-1:0] offset_x,
    input  logic signed [msct_pkg::COORD_W-1:0] offset_y,
    input  logic signed [msct_pkg::COORD_W-1:0] offset_z,
    input  logic signed [msct_pkg::COORD_W-1:0] rel_vel_x,
    input  logic signed [msct_pkg::COORD_W-1:0] rel_vel_y,
    input  logic signed [msct_pkg::COORD_W-1:0] rel_vel_z,
    input  logic [msct_pkg::R_W-1:0]      radius_sum,
    input  logic [msct_pkg::TAG_W-1:0]    ghost_tag,
    input  logic                          crossing_flag,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          hit,
    output logic [ID_BITS-1:0]            hit_first_id,
    output logic [ID_BITS-1:0]            hit_second_id,
    output logic [msct_pkg::TAG_W-1:0]    hit_ghost_tag,
    output logic                          hit_crossing,
    output logic signed [msct_pkg::TIME_W-1:0] contact_time
);
    import msct_pkg::*;

    localparam int TAG_BITS  = $bits(tag_t);
    localparam int SQ_SIDE_W = 2 * ID_BITS + TAG_BITS + $bits(norm_t) + 1;
    localparam int DV_SIDE_W = 2 * ID_BITS + TAG_BITS + 3;

    logic [H_W-1:0] hsl_reg;
    logic           advance;

    // Front end outputs.
    logic [COORD_W-1:0] pos [3];
    logic [COORD_W-1:0] vel [3];
    tag_t               in_tag;
    logic               f_valid;
    logic [ID_BITS-1:0] f_first, f_second;
    tag_t               f_tag;
    norm_t              f_norm;
    logic [DW-1:0]      f_d;
    logic               f_dneg;

    // Square root outputs.
    logic                 s_valid;
    logic [RW-1:0]        s_root;
    logic [SQ_SIDE_W-1:0] s_side;
    logic [ID_BITS-1:0]   s_first, s_second;
    tag_t                 s_tag;
    norm_t                s_norm;
    logic                 s_dneg;

    // |q| stage.
    logic               q_valid_reg;
    logic [QW-1:0]      qm_reg;
    logic [NW-1:0]      qa_reg, qc_reg;
    logic               q_cneg_reg, q_qneg_reg, q_live_reg;
    logic [ID_BITS-1:0] q_first_reg, q_second_reg;
    tag_t               q_tag_reg;

    // Divider outputs.
    logic                 d_valid;
    logic [1:0][QW-1:0]   d_num, d_den;
    logic [1:0][QB-1:0]   d_quo;
    logic [1:0]           d_ovf;
    logic [DV_SIDE_W-1:0] d_side;
    logic [ID_BITS-1:0]   d_first, d_second;
    tag_t                 d_tag;
    logic                 d_cneg, d_qneg, d_live;

    // Final decision.
    logic [TM_W-1:0]        m1, m2;
    logic signed [TS_W-1:0] t1, t2, lo, hi, hw;
    logic                   in_window, straddle;
    logic                   fin_hit;
    logic [TIME_W-1:0]      fin_time;

    // Output register and skid register.
    logic               out_valid_reg, skid_valid_reg;
    logic               out_hit_reg, skid_hit_reg;
    logic [ID_BITS-1:0] out_first_reg, out_second_reg, skid_first_reg, skid_second_reg;
    tag_t               out_tag_reg, skid_tag_reg;
    logic [TIME_W-1:0]  out_time_reg, skid_time_reg;
    logic               out_take, out_from_skid, out_from_pipe, skid_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsl_reg <= HALF_STEP_RESET;
        end
        else if (half_step_length_we)
        begin
            hsl_reg <= half_step_length;
        end
    end

    // The pipeline moves as one while the skid register is free.
    assign advance    = !skid_valid_reg;
    assign item_stall = skid_valid_reg;

    assign pos[0] = offset_x;
    assign pos[1] = offset_y;
    assign pos[2] = offset_z;
    assign vel[0] = rel_vel_x;
    assign vel[1] = rel_vel_y;
    assign vel[2] = rel_vel_z;
    assign in_tag = '{ghost_tag: ghost_tag, crossing: crossing_flag};

    msct_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (item_valid),
        .in_first_id   (first_id),
        .in_second_id  (second_id),
        .in_pos        (pos),
        .in_vel        (vel),
        .in_radius     (radius_sum),
        .in_tag        (in_tag),
        .out_valid     (f_valid),
        .out_first_id  (f_first),
        .out_second_id (f_second),
        .out_tag       (f_tag),
        .out_norm      (f_norm),
        .out_d         (f_d),
        .out_d_neg     (f_dneg)
    );

    msct_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (f_valid),
        .in_d      (f_d),
        .in_side   ({f_first, f_second, f_tag, f_norm, f_dneg}),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    assign {s_first, s_second, s_tag, s_norm, s_dneg} = s_side;

    // |q| = |b/2| + root. The pair can only hit with a real root and nonzero q.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            q_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qm_reg       <= QW'(s_norm.bm) + QW'(s_root);
            qa_reg       <= s_norm.a;
            qc_reg       <= s_norm.cm;
            q_cneg_reg   <= s_norm.c_neg;
            q_qneg_reg   <= !s_norm.b_neg;
            q_live_reg   <= !s_dneg && ((s_norm.bm != '0) || (s_root != '0));
            q_first_reg  <= s_first;
            q_second_reg <= s_second;
            q_tag_reg    <= s_tag;
        end
    end

    // Lane 0 gives |c/q|, lane 1 gives |q/a|; a zero a saturates lane 1.
    assign d_num[0] = QW'(qc_reg);
    assign d_den[0] = qm_reg;
    assign d_num[1] = qm_reg;
    assign d_den[1] = QW'(qa_reg);

    msct_div #(
        .FRACTION_BITS (FRACTION_BITS),
        .SIDE_W        (DV_SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (q_valid_reg),
        .in_num    (d_num),
        .in_den    (d_den),
        .in_side   ({q_first_reg, q_second_reg, q_tag_reg, q_cneg_reg, q_qneg_reg, q_live_reg}),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_ovf   (d_ovf),
        .out_side  (d_side)
    );

    assign {d_first, d_second, d_tag, d_cneg, d_qneg, d_live} = d_side;

    // Clip both times to 2^32, sign them, order them and test the window.
    always_comb
    begin
        m1 = (d_ovf[0] || d_quo[0][QB-1]) ? TIME_CAP : TM_W'(d_quo[0]);
        m2 = (d_ovf[1] || d_quo[1][QB-1]) ? TIME_CAP : TM_W'(d_quo[1]);
        t1 = (d_cneg != d_qneg) ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
        t2 = d_qneg ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
        if (t1 > t2)
        begin
            lo = t2;
            hi = t1;
        end
        else
        begin
            lo = t1;
            hi = t2;
        end
        hw        = $signed({{(TS_W - H_W){1'b0}}, hsl_reg});
        in_window = (lo > -hw) && (lo < hw);
        straddle  = (lo < -hw) && (hi > hw);
        fin_hit   = d_live && (in_window || straddle);
        fin_time  = (d_live && in_window) ? lo[TIME_W-1:0] : '0;
    end

    assign out_take      = out_valid_reg && !result_stall;
    assign out_from_skid = skid_valid_reg && out_take;
    assign out_from_pipe = !skid_valid_reg && (!out_valid_reg || out_take);
    assign skid_load     = !skid_valid_reg && out_valid_reg && !out_take && d_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_from_skid)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else if (out_from_pipe)
            begin
                out_valid_reg <= d_valid;
            end
            else if (skid_load)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            out_hit_reg    <= skid_hit_reg;
            out_first_reg  <= skid_first_reg;
            out_second_reg <= skid_second_reg;
            out_tag_reg    <= skid_tag_reg;
            out_time_reg   <= skid_time_reg;
        end
        else if (out_from_pipe)
        begin
            out_hit_reg    <= fin_hit;
            out_first_reg  <= d_first;
            out_second_reg <= d_second;
            out_tag_reg    <= d_tag;
            out_time_reg   <= fin_time;
        end
        if (skid_load)
        begin
            skid_hit_reg    <= fin_hit;
            skid_first_reg  <= d_first;
            skid_second_reg <= d_second;
            skid_tag_reg    <= d_tag;
            skid_time_reg   <= fin_time;
        end
    end

    assign result_valid  = out_valid_reg;
    assign hit           = out_hit_reg;
    assign hit_first_id  = out_first_reg;
    assign hit_second_id = out_second_reg;
    assign hit_ghost_tag = out_tag_reg.ghost_tag;
    assign hit_crossing  = out_tag_reg.crossing;
    assign contact_time  = $signed(out_time_reg);

    `MSCT_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word held without an output word")
    `MSCT_ASSERT_NXT(a_skid_catches, out_valid_reg && result_stall && !skid_valid_reg && d_valid, skid_valid_reg, "pipeline word dropped while output stalled")
    `MSCT_ASSERT_IMP(a_miss_time_zero, out_valid_reg && !out_hit_reg, out_time_reg == '0, "miss word carries a nonzero time")
    `MSCT_ASSERT_IMP(a_time_in_window, out_valid_reg && out_hit_reg && (out_time_reg != '0), ($signed(out_time_reg) < $signed({1'b0, hsl_reg})) && ($signed(out_time_reg) > -$signed({1'b0, hsl_reg})), "contact time outside the step window")

endmodule

// ----- rtl/msct_front.sv -----
// Coefficient front end: products, sums, normalization and discriminant.
`timescale 1ns / 1ps
module msct_front #(
    parameter int ID_BITS = msct_pkg::ID_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [ID_BITS-1:0]              in_first_id,
    input  logic [ID_BITS-1:0]              in_second_id,
    input  logic [msct_pkg::COORD_W-1:0]    in_pos [3],
    input  logic [msct_pkg::COORD_W-1:0]    in_vel [3],
    input  logic [msct_pkg::R_W-1:0]        in_radius,
    input  msct_pkg::tag_t                  in_tag,
    output logic                            out_valid,
    output logic [ID_BITS-1:0]              out_first_id,
    output logic [ID_BITS-1:0]              out_second_id,
    output msct_pkg::tag_t                  out_tag,
    output msct_pkg::norm_t                 out_norm,
    output logic [msct_pkg::DW-1:0]         out_d,
    output logic                            out_d_neg
);
    import msct_pkg::*;

    logic               valid_reg  [FRONT_STAGES];
    logic [ID_BITS-1:0] first_reg  [FRONT_STAGES];
    logic [ID_BITS-1:0] second_reg [FRONT_STAGES];
    tag_t               tag_reg    [FRONT_STAGES];

    // Stage 1: magnitudes.
    logic [COORD_W-1:0] pm_reg [3];
    logic [COORD_W-1:0] vm_reg [3];
    logic               xn1_reg [3];
    logic [R_W-1:0]     r_reg;
    // Stage 2: products.
    logic [PROD_W-1:0]  vv_reg [3];
    logic [PROD_W-1:0]  pp_reg [3];
    logic [PROD_W-1:0]  vp_reg [3];
    logic               xn2_reg [3];
    logic [2*R_W-1:0]   rr2_reg;
    // Stage 3: sums.
    logic [PROD_W-1:0]  a3_reg, psq_reg, bpos_reg, bneg_reg;
    logic [2*R_W-1:0]   rr3_reg;
    // Stage 4: signed magnitudes of b/2 and c.
    logic [PROD_W-1:0]  a4_reg, bm4_reg, cm4_reg;
    logic               bn4_reg, cn4_reg;
    // Stages 5 to 8.
    norm_t              norm5_reg, norm6_reg, norm7_reg, norm8_reg;
    logic [2*SPLIT-1:0] bll_reg, all_reg;
    logic [SPLIT+HI_W-1:0] blh_reg, alh_reg, ahl_reg;
    logic [2*HI_W-1:0]  bhh_reg, ahh_reg;
    logic [PW-1:0]      bb_reg, ac_reg;
    logic [DW-1:0]      d_reg;
    logic               dneg_reg;

    logic [COORD_W-1:0] pm_c [3];
    logic [COORD_W-1:0] vm_c [3];
    logic [PROD_W-1:0]  a_c, psq_c, bpos_c, bneg_c, rr_c, top_c;
    logic [1:0]         sh_c;
    logic [PW-1:0]      bb_c, ac_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pm_c[i] = in_pos[i][COORD_W-1] ? (~in_pos[i] + COORD_W'(1)) : in_pos[i];
            vm_c[i] = in_vel[i][COORD_W-1] ? (~in_vel[i] + COORD_W'(1)) : in_vel[i];
        end
    end

    always_comb
    begin
        a_c    = vv_reg[0] + vv_reg[1] + vv_reg[2];
        psq_c  = pp_reg[0] + pp_reg[1] + pp_reg[2];
        bpos_c = '0;
        bneg_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (xn2_reg[i])
            begin
                bneg_c = bneg_c + vp_reg[i];
            end
            else
            begin
                bpos_c = bpos_c + vp_reg[i];
            end
        end
    end

    // Shift all three coefficients together until each is below 2^61.
    always_comb
    begin
        rr_c  = PROD_W'(rr3_reg);
        top_c = a4_reg | bm4_reg | cm4_reg;
        priority if (top_c[PROD_W-1])
        begin
            sh_c = 2'd3;
        end
        else if (top_c[PROD_W-2])
        begin
            sh_c = 2'd2;
        end
        else if (top_c[PROD_W-3])
        begin
            sh_c = 2'd1;
        end
        else
        begin
            sh_c = 2'd0;
        end
    end

    always_comb
    begin
        bb_c = (PW'(bhh_reg) << (2 * SPLIT)) + (PW'(blh_reg) << (SPLIT + 1)) + PW'(bll_reg);
        ac_c = (PW'(ahh_reg) << (2 * SPLIT))
             + ((PW'(alh_reg) + PW'(ahl_reg)) << SPLIT) + PW'(all_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRONT_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < FRONT_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            first_reg[0]  <= in_first_id;
            second_reg[0] <= in_second_id;
            tag_reg[0]    <= in_tag;
            for (int k = 1; k < FRONT_STAGES; k++)
            begin
                first_reg[k]  <= first_reg[k-1];
                second_reg[k] <= second_reg[k-1];
                tag_reg[k]    <= tag_reg[k-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                pm_reg[i]  <= pm_c[i];
                vm_reg[i]  <= vm_c[i];
                xn1_reg[i] <= in_pos[i][COORD_W-1] ^ in_vel[i][COORD_W-1];
                vv_reg[i]  <= PROD_W'(vm_reg[i]) * PROD_W'(vm_reg[i]);
                pp_reg[i]  <= PROD_W'(pm_reg[i]) * PROD_W'(pm_reg[i]);
                vp_reg[i]  <= PROD_W'(vm_reg[i]) * PROD_W'(pm_reg[i]);
                xn2_reg[i] <= xn1_reg[i];
            end
            r_reg   <= in_radius;
            rr2_reg <= (2*R_W)'(r_reg) * (2*R_W)'(r_reg);

            a3_reg   <= a_c;
            psq_reg  <= psq_c;
            bpos_reg <= bpos_c;
            bneg_reg <= bneg_c;
            rr3_reg  <= rr2_reg;

            a4_reg  <= a3_reg;
            bn4_reg <= bneg_reg > bpos_reg;
            bm4_reg <= (bneg_reg > bpos_reg) ? bneg_reg - bpos_reg : bpos_reg - bneg_reg;
            cn4_reg <= rr_c > psq_reg;
            cm4_reg <= (rr_c > psq_reg) ? rr_c - psq_reg : psq_reg - rr_c;

            norm5_reg.a     <= NW'(a4_reg >> sh_c);
            norm5_reg.bm    <= NW'(bm4_reg >> sh_c);
            norm5_reg.cm    <= NW'(cm4_reg >> sh_c);
            norm5_reg.b_neg <= bn4_reg;
            norm5_reg.c_neg <= cn4_reg;

            bll_reg <= (2*SPLIT)'(norm5_reg.bm[SPLIT-1:0]) * (2*SPLIT)'(norm5_reg.bm[SPLIT-1:0]);
            blh_reg <= (SPLIT+HI_W)'(norm5_reg.bm[SPLIT-1:0])
                     * (SPLIT+HI_W)'(norm5_reg.bm[NW-1:SPLIT]);
            bhh_reg <= (2*HI_W)'(norm5_reg.bm[NW-1:SPLIT]) * (2*HI_W)'(norm5_reg.bm[NW-1:SPLIT]);
            all_reg <= (2*SPLIT)'(norm5_reg.a[SPLIT-1:0]) * (2*SPLIT)'(norm5_reg.cm[SPLIT-1:0]);
            alh_reg <= (SPLIT+HI_W)'(norm5_reg.a[SPLIT-1:0])
                     * (SPLIT+HI_W)'(norm5_reg.cm[NW-1:SPLIT]);
            ahl_reg <= (SPLIT+HI_W)'(norm5_reg.a[NW-1:SPLIT])
                     * (SPLIT+HI_W)'(norm5_reg.cm[SPLIT-1:0]);
            ahh_reg <= (2*HI_W)'(norm5_reg.a[NW-1:SPLIT]) * (2*HI_W)'(norm5_reg.cm[NW-1:SPLIT]);
            norm6_reg <= norm5_reg;

            bb_reg    <= bb_c;
            ac_reg    <= ac_c;
            norm7_reg <= norm6_reg;

            d_reg     <= norm7_reg.c_neg ? DW'(bb_reg) + DW'(ac_reg) : DW'(bb_reg) - DW'(ac_reg);
            dneg_reg  <= !norm7_reg.c_neg && (bb_reg < ac_reg);
            norm8_reg <= norm7_reg;
        end
    end

    assign out_valid     = valid_reg[FRONT_STAGES-1];
    assign out_first_id  = first_reg[FRONT_STAGES-1];
    assign out_second_id = second_reg[FRONT_STAGES-1];
    assign out_tag       = tag_reg[FRONT_STAGES-1];
    assign out_norm      = norm8_reg;
    assign out_d         = d_reg;
    assign out_d_neg     = dneg_reg;

endmodule

// ----- rtl/msct_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module msct_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  logic [msct_pkg::DW-1:0]  in_d,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic [msct_pkg::RW-1:0]  out_root,
    output logic [SIDE_W-1:0]        out_side
);
    import msct_pkg::*;

    logic              valid_reg [RW];
    logic [SW-1:0]     rem_reg   [RW];
    logic [RW-1:0]     root_reg  [RW];
    logic [SIDE_W-1:0] side_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam int BIT = RW - 1 - k;
        logic              v_in;
        logic [SW-1:0]     rem_in;
        logic [RW-1:0]     root_in;
        logic [SIDE_W-1:0] side_in;
        logic [SW-1:0]     trial;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = SW'(in_d);
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Root bits found so far sit above BIT, so the two terms never overlap.
        assign trial = (SW'(root_in) << (BIT + 1)) | (SW'(1) << (2 * BIT));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                side_reg[k] <= side_in;
                if (rem_in >= trial)
                begin
                    rem_reg[k]  <= rem_in - trial;
                    root_reg[k] <= root_in | (RW'(1) << BIT);
                end
                else
                begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

// ----- rtl/msct_div.sv -----
// Two-lane pipelined restoring divider for scaled times, one quotient bit per stage after the scaling stage.
`timescale 1ns / 1ps
module msct_div #(
    parameter int FRACTION_BITS = msct_pkg::FRACTION_BITS_DEFAULT,
    parameter int SIDE_W        = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic [1:0][msct_pkg::QW-1:0]   in_num,
    input  logic [1:0][msct_pkg::QW-1:0]   in_den,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [1:0][msct_pkg::QB-1:0]   out_quo,
    output logic [1:0]                     out_ovf,
    output logic [SIDE_W-1:0]              out_side
);
    import msct_pkg::*;

    // Stage 0 scales the numerator and flags quotients of 2^QB or more.
    logic              valid_reg [QB+1];
    logic [SIDE_W-1:0] side_reg  [QB+1];
    logic [1:0][CW-1:0] rem_reg  [QB+1];
    logic [1:0][QW-1:0] den_reg  [QB+1];
    logic [1:0][QB-1:0] quo_reg  [QB+1];
    logic [1:0]         ovf_reg  [QB+1];

    logic [1:0][CW-1:0] scaled;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            scaled[l] = CW'(in_num[l]) << FRACTION_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= QB; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= in_side;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= scaled[l];
                den_reg[0][l] <= in_den[l];
                quo_reg[0][l] <= '0;
                ovf_reg[0][l] <= scaled[l] >= (CW'(in_den[l]) << QB);
            end
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam int BIT = QB - k;
        logic [1:0][CW-1:0] trial;

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = CW'(den_reg[k-1][l]) << BIT;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                side_reg[k] <= side_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                for (int l = 0; l < 2; l++)
                begin
                    if (rem_reg[k-1][l] >= trial[l])
                    begin
                        rem_reg[k][l] <= rem_reg[k-1][l] - trial[l];
                        quo_reg[k][l] <= {quo_reg[k-1][l][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k][l] <= rem_reg[k-1][l];
                        quo_reg[k][l] <= {quo_reg[k-1][l][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_quo   = quo_reg[QB];
    assign out_ovf   = ovf_reg[QB];
    assign out_side  = side_reg[QB];

endmodule
